// File: src/sparse_factor_gradient_accumulate_assert.svh
// Assertion macros shared by the sparse factor gradient accumulator modules.
`ifndef SPARSE_FACTOR_GRADIENT_ACCUMULATE_ASSERT_SVH
`define SPARSE_FACTOR_GRADIENT_ACCUMULATE_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define SFGA_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SFGA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/sfga_pkg.sv
// Package: types, codes and arithmetic helpers of the sparse factor gradient accumulator.
`default_nettype none
package sfga_pkg;

	localparam int MAX_RANK_DEF     = 16;
	localparam int ENTITY_COUNT_DEF = 1024;
	localparam int QUEUE_DEPTH      = 4;
	localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
	localparam int DATA_W           = 32;
	localparam int GRAD_W           = DATA_W + 1;

	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_OBS  = 2'd1;
	localparam logic [1:0] REQ_READ = 2'd2;

	localparam logic [2:0] TBL_OWN     = 3'd0;
	localparam logic [2:0] TBL_OTHER   = 3'd1;
	localparam logic [2:0] TBL_COV     = 3'd2;
	localparam logic [2:0] TBL_GRAD    = 3'd3;
	localparam logic [2:0] TBL_ROW_OFF = 3'd4;
	localparam logic [2:0] TBL_COL_OFF = 3'd5;

	localparam logic [1:0] REG_STEP_SCALE  = 2'd0;
	localparam logic [1:0] REG_ENTITY_MODE = 2'd1;
	localparam logic [1:0] REG_RANK_IN_USE = 2'd2;

	localparam logic [30:0] STEP_SCALE_RESET = 31'd65536;
	localparam logic [4:0]  RANK_RESET       = 5'd16;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [2:0]         table_select;
		logic [9:0]         row_index;
		logic [9:0]         col_index;
		logic [3:0]         lane;
		logic signed [31:0] data_value;
	} in_t;

	typedef struct packed {
		logic signed [31:0] read_data;
		logic               saturated;
	} out_t;

	typedef enum logic [1:0] {
		K_LOAD  = 2'd0,
		K_OBS   = 2'd1,
		K_READ  = 2'd2,
		K_READZ = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [2:0]         sel;
		logic [9:0]         row;
		logic [9:0]         col;
		logic [3:0]         lane;
		logic signed [31:0] data;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} qhead_t;

	typedef struct packed {
		logic [30:0] step;
		logic        mode;
		logic [4:0]  rank;
	} cfg_t;

	typedef struct packed {
		logic               flag;
		logic signed [31:0] v;
	} sat_t;

	function automatic logic signed [47:0] round_q(input logic signed [63:0] p);
		logic signed [63:0] y;
		y = p + 64'sd32768;
		return 48'(y >>> 16);
	endfunction

	function automatic sat_t sat32(input logic signed [63:0] x);
		sat_t r;
		if (x > 64'sd2147483647) begin
			r.flag = 1'b1;
			r.v    = 32'sh7fffffff;
		end else if (x < -64'sd2147483648) begin
			r.flag = 1'b1;
			r.v    = 32'sh80000000;
		end else begin
			r.flag = 1'b0;
			r.v    = 32'(x);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: src/sparse_factor_gradient_accumulate.sv
// Top level of the sparse factor gradient accumulator.
// Input channel in_valid/in_stall/in_item: load, observation and read transactions.
// A load writes one table entry; an observation forms the residual from the own and
// other factor rows and offsets, then adds the scaled increment to each gradient lane;
// a read returns one gradient entry and its sticky saturation flag on the output
// channel out_valid/out_stall/out_item. Loads and observations produce no result.
// Transactions pass through a four-entry command queue into a sequencer that runs
// one command at a time. A read passes a read state and a data state to the output
// register; an observation takes its R lanes in use one lane per cycle through the
// dot product pipeline, then one lane per cycle through the update pipeline, both
// paced by the single read port of each table.
// A receiver stall holds the result in the output register; later loads and
// observations keep running, a further read waits for the register to free.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data), written idle.
// Reset clears control state and the configuration; table contents are undefined
// until loaded, and no clearing pass runs.
`default_nettype none
module sparse_factor_gradient_accumulate import sfga_pkg::*; #(
	parameter int MAX_RANK     = MAX_RANK_DEF,
	parameter int ENTITY_COUNT = ENTITY_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_t         in_item,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_t             out_item,
	input  wire logic        cfg_write,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [30:0] cfg_data
);

	cfg_t   cfg_q;
	qhead_t head;
	logic   pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step <= STEP_SCALE_RESET;
			cfg_q.mode <= 1'b0;
			cfg_q.rank <= RANK_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_STEP_SCALE:  cfg_q.step <= cfg_data;
				REG_ENTITY_MODE: cfg_q.mode <= cfg_data[0];
				REG_RANK_IN_USE: cfg_q.rank <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	sfga_front #(.MAX_RANK(MAX_RANK), .ENTITY_COUNT(ENTITY_COUNT)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_item, .head, .pop
	);

	sfga_back #(.MAX_RANK(MAX_RANK), .ENTITY_COUNT(ENTITY_COUNT)) u_back (
		.clk, .arst_n, .cfg(cfg_q), .head, .pop, .out_valid, .out_stall, .out_item
	);

endmodule
`default_nettype wire

// File: src/sfga_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sfga_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: src/sfga_front.sv
// Front end: accepts input transactions, classifies them and queues commands.
`default_nettype none
`include "sparse_factor_gradient_accumulate_assert.svh"
module sfga_front import sfga_pkg::*; #(
	parameter int MAX_RANK     = MAX_RANK_DEF,
	parameter int ENTITY_COUNT = ENTITY_COUNT_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire in_t  in_item,
	output qhead_t    head,
	input  wire logic pop
);

	cmd_t                q_mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]     cnt_q;
	logic                keep, push;
	logic                row_ok, col_ok, lane_ok;
	cmd_t                cmd;

	always_comb begin
		row_ok   = 32'(in_item.row_index) < ENTITY_COUNT;
		col_ok   = 32'(in_item.col_index) < ENTITY_COUNT;
		lane_ok  = 32'(in_item.lane) < MAX_RANK;
		cmd.sel  = in_item.table_select;
		cmd.row  = in_item.row_index;
		cmd.col  = in_item.col_index;
		cmd.lane = in_item.lane;
		cmd.data = in_item.data_value;
		cmd.kind = K_LOAD;
		keep     = 1'b0;
		unique case (in_item.req_type)
			REQ_LOAD: begin
				keep = row_ok && (in_item.table_select == TBL_ROW_OFF ||
					in_item.table_select == TBL_COL_OFF ||
					(lane_ok && in_item.table_select <= TBL_GRAD));
			end
			REQ_OBS: begin
				cmd.kind = K_OBS;
				keep     = row_ok && col_ok;
			end
			REQ_READ: begin
				cmd.kind = (row_ok && lane_ok) ? K_READ : K_READZ;
				keep     = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign in_stall   = cnt_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign push       = in_valid && !in_stall && keep;
	assign head.valid = cnt_q != '0;
	assign head.cmd   = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cmd;
		end
	end

	`SFGA_ASSERT(a_cnt_bound, 1'b1, cnt_q <= (QPTR_W+1)'(QUEUE_DEPTH), "queue count overflow")
	`SFGA_ASSERT(a_pop_nonempty, pop, cnt_q != '0, "pop from empty queue")
	`SFGA_ASSERT_NEXT(a_cnt_inc, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "count lost a push")

endmodule
`default_nettype wire

// File: src/sfga_back.sv
// Back end: executes queued commands against the factor and gradient tables.
`default_nettype none
`include "sparse_factor_gradient_accumulate_assert.svh"
module sfga_back import sfga_pkg::*; #(
	parameter int MAX_RANK     = MAX_RANK_DEF,
	parameter int ENTITY_COUNT = ENTITY_COUNT_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cfg_t   cfg,
	input  wire qhead_t head,
	output logic        pop,
	output logic        out_valid,
	input  wire logic   out_stall,
	output out_t        out_item
);

	localparam int DEPTH  = ENTITY_COUNT * MAX_RANK;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int EW     = $clog2(ENTITY_COUNT);
	localparam int KW     = $clog2(MAX_RANK + 1);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_LOAD  = 9'b000000010,
		S_DOT   = 9'b000000100,
		S_DOTW  = 9'b000001000,
		S_GRAD  = 9'b000010000,
		S_GRADW = 9'b000100000,
		S_READ  = 9'b001000000,
		S_RDATA = 9'b010000000,
		S_READZ = 9'b100000000
	} state_t;

	state_t              state_q;
	cmd_t                cur_q;
	logic [ADDR_W-1:0]   cur_addr_q, own_base_q, other_base_q;
	logic [KW-1:0]       k_q, k_nxt, rank_eff;
	logic [9:0]          own_ent, other_ent;
	logic signed [63:0]  acc_q;
	logic signed [31:0]  resid_q;
	logic                rsat_q;
	logic                out_valid_q;
	out_t                out_item_q;
	logic                slot_free, pipe_empty, issue;

	logic                iss_s1, ph_s1, v_s2, ph_s2, v_s3, v_s4;
	logic [ADDR_W-1:0]   addr_s1, addr_s2, addr_s3, addr_s4;
	logic signed [63:0]  m1_s2, m2_s2, m3_s4;
	logic [GRAD_W-1:0]   grad_s2, grad_s3, grad_s4;
	logic signed [31:0]  inner_s3;
	logic                isat_s3, isat_s4;

	logic [DATA_W-1:0]   own_rd, other_rd, cov_rd, roff_rd, coff_rd;
	logic [GRAD_W-1:0]   grad_rd, grad_wdata;
	logic [ADDR_W-1:0]   lane_addr_own, lane_addr_other, grad_waddr, grad_raddr;
	logic                load_own, load_other, load_cov, load_grad, load_roff, load_coff;
	logic                grad_we, grad_re;
	logic signed [31:0]  mx;
	sat_t                inner_sat, sum_sat, resid_sat;

	assign rank_eff  = (32'(cfg.rank) > MAX_RANK) ? KW'(MAX_RANK) : KW'(cfg.rank);
	assign k_nxt     = k_q + KW'(1);
	assign own_ent   = cfg.mode ? head.cmd.col : head.cmd.row;
	assign other_ent = cfg.mode ? head.cmd.row : head.cmd.col;
	assign slot_free = !out_valid_q || !out_stall;
	assign pipe_empty = !iss_s1 && !v_s2 && !v_s3 && !v_s4;
	assign pop       = state_q == S_IDLE && head.valid;
	assign issue     = state_q == S_DOT || state_q == S_GRAD;

	assign lane_addr_own   = own_base_q + ADDR_W'(k_q);
	assign lane_addr_other = other_base_q + ADDR_W'(k_q);

	assign load_own   = state_q == S_LOAD && cur_q.sel == TBL_OWN;
	assign load_other = state_q == S_LOAD && cur_q.sel == TBL_OTHER;
	assign load_cov   = state_q == S_LOAD && cur_q.sel == TBL_COV;
	assign load_grad  = state_q == S_LOAD && cur_q.sel == TBL_GRAD;
	assign load_roff  = state_q == S_LOAD && cur_q.sel == TBL_ROW_OFF;
	assign load_coff  = state_q == S_LOAD && cur_q.sel == TBL_COL_OFF;

	always_comb begin
		sum_sat    = sat32(64'($signed(grad_s4[31:0])) + 64'(round_q(m3_s4)));
		grad_we    = load_grad || v_s4;
		grad_waddr = load_grad ? cur_addr_q : addr_s4;
		grad_wdata = load_grad ? {1'b0, cur_q.data}
			: {grad_s4[32] || isat_s4 || sum_sat.flag, sum_sat.v};
		grad_re    = state_q == S_GRAD || state_q == S_READ;
		grad_raddr = (state_q == S_GRAD) ? lane_addr_own : cur_addr_q;
		mx         = ph_s1 ? resid_q : $signed(own_rd);
		inner_sat  = sat32(64'(round_q(m1_s2)) + 64'(round_q(m2_s2)));
		resid_sat  = sat32(acc_q - 64'(cur_q.data) + 64'($signed(roff_rd))
			+ 64'($signed(coff_rd)));
	end

	sfga_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_own (
		.clk, .we(load_own), .waddr(cur_addr_q), .wdata(cur_q.data),
		.re(issue), .raddr(lane_addr_own), .rdata(own_rd)
	);
	sfga_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_other (
		.clk, .we(load_other), .waddr(cur_addr_q), .wdata(cur_q.data),
		.re(issue), .raddr(lane_addr_other), .rdata(other_rd)
	);
	sfga_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_cov (
		.clk, .we(load_cov), .waddr(cur_addr_q), .wdata(cur_q.data),
		.re(state_q == S_GRAD), .raddr(lane_addr_other), .rdata(cov_rd)
	);
	sfga_ram #(.WIDTH(GRAD_W), .DEPTH(DEPTH)) u_grad (
		.clk, .we(grad_we), .waddr(grad_waddr), .wdata(grad_wdata),
		.re(grad_re), .raddr(grad_raddr), .rdata(grad_rd)
	);
	sfga_ram #(.WIDTH(DATA_W), .DEPTH(ENTITY_COUNT)) u_roff (
		.clk, .we(load_roff), .waddr(EW'(cur_q.row)), .wdata(cur_q.data),
		.re(state_q == S_DOT), .raddr(EW'(cur_q.row)), .rdata(roff_rd)
	);
	sfga_ram #(.WIDTH(DATA_W), .DEPTH(ENTITY_COUNT)) u_coff (
		.clk, .we(load_coff), .waddr(EW'(cur_q.row)), .wdata(cur_q.data),
		.re(state_q == S_DOT), .raddr(EW'(cur_q.col)), .rdata(coff_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			iss_s1      <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
		end else begin
			iss_s1 <= issue;
			v_s2   <= iss_s1;
			v_s3   <= v_s2 && ph_s2;
			v_s4   <= v_s3;
			if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (head.valid) begin
						unique case (head.cmd.kind)
							K_LOAD:  state_q <= S_LOAD;
							K_OBS:   state_q <= (rank_eff == '0) ? S_IDLE : S_DOT;
							K_READ:  state_q <= S_READ;
							K_READZ: state_q <= S_READZ;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_LOAD: state_q <= S_IDLE;
				S_DOT: begin
					if (k_nxt == rank_eff) begin
						state_q <= S_DOTW;
					end
				end
				S_DOTW: begin
					if (pipe_empty) begin
						state_q <= S_GRAD;
					end
				end
				S_GRAD: begin
					if (k_nxt == rank_eff) begin
						state_q <= S_GRADW;
					end
				end
				S_GRADW: begin
					if (pipe_empty) begin
						state_q <= S_IDLE;
					end
				end
				S_READ: state_q <= S_RDATA;
				S_RDATA, S_READZ: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q        <= head.cmd;
			cur_addr_q   <= ADDR_W'(32'(head.cmd.row) * MAX_RANK + 32'(head.cmd.lane));
			own_base_q   <= ADDR_W'(32'(own_ent) * MAX_RANK);
			other_base_q <= ADDR_W'(32'(other_ent) * MAX_RANK);
			k_q          <= '0;
			acc_q        <= '0;
		end else begin
			if (issue) begin
				k_q <= k_nxt;
			end
			if (state_q == S_DOTW && pipe_empty) begin
				k_q     <= '0;
				resid_q <= resid_sat.v;
				rsat_q  <= resid_sat.flag;
			end
			if (v_s2 && !ph_s2) begin
				acc_q <= acc_q + 64'(round_q(m1_s2));
			end
		end
		ph_s1   <= state_q == S_GRAD;
		addr_s1 <= lane_addr_own;
		m1_s2   <= 64'(mx) * 64'($signed(other_rd));
		m2_s2   <= 64'($signed(own_rd)) * 64'($signed(cov_rd));
		grad_s2 <= grad_rd;
		ph_s2   <= ph_s1;
		addr_s2 <= addr_s1;
		inner_s3 <= inner_sat.v;
		isat_s3  <= inner_sat.flag || rsat_q;
		grad_s3  <= grad_s2;
		addr_s3  <= addr_s2;
		m3_s4    <= 64'($signed({1'b0, cfg.step})) * 64'(inner_s3);
		isat_s4  <= isat_s3;
		grad_s4  <= grad_s3;
		addr_s4  <= addr_s3;
		if (slot_free && state_q == S_RDATA) begin
			out_item_q.read_data <= $signed(grad_rd[31:0]);
			out_item_q.saturated <= grad_rd[32];
		end else if (slot_free && state_q == S_READZ) begin
			out_item_q <= '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`SFGA_ASSERT(a_idle_drained, state_q == S_IDLE, pipe_empty, "pipeline busy in idle")
	`SFGA_ASSERT(a_wb_in_grad, v_s4, state_q == S_GRAD || state_q == S_GRADW,
		"gradient write-back outside update")
	`SFGA_ASSERT(a_out_src, $rose(out_valid_q),
		$past(state_q == S_RDATA) || $past(state_q == S_READZ), "result without read")

endmodule
`default_nettype wire

// File: sim/sparse_factor_gradient_accumulate_checker.sv
// Checker for the sparse factor gradient accumulator: predicts read results and compares them.
module sparse_factor_gradient_accumulate_checker import sfga_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_t         in_item,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_t        out_item,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data,
	output int          fail_count,
	output int          pending_reads,
	output int          reads_seen,
	output int          obs_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NR = MAX_RANK_DEF;
	localparam int NE = ENTITY_COUNT_DEF;

	logic signed [31:0] own_tbl [NE*NR];
	logic signed [31:0] other_tbl [NE*NR];
	logic signed [31:0] cov_tbl [NE*NR];
	logic signed [31:0] grad_tbl [NE*NR];
	logic sat_tbl [NE*NR];
	logic signed [31:0] row_off [NE];
	logic signed [31:0] col_off [NE];
	logic [30:0] tau;
	logic mode;
	logic [4:0] rank_cfg;
	out_t gradient_reads [$];

	function automatic logic signed [63:0] q_round(input logic signed [63:0] p);
		logic signed [63:0] y;
		y = p + 64'sd32768;
		return y >>> 16;
	endfunction

	function automatic logic signed [63:0] clamp32(input logic signed [63:0] x,
			inout logic flag);
		if (x > 64'sd2147483647) begin
			flag = 1'b1;
			return 64'sd2147483647;
		end
		if (x < -64'sd2147483648) begin
			flag = 1'b1;
			return -64'sd2147483648;
		end
		return x;
	endfunction

	task automatic accumulate_gradient(input in_t t);
		int own, oth, r, oi, ti;
		logic signed [63:0] acc, resid, inner, inc;
		logic rs, s;
		own = mode ? t.col_index : t.row_index;
		oth = mode ? t.row_index : t.col_index;
		r = rank_cfg > NR ? NR : rank_cfg;
		acc = 0;
		rs = 1'b0;
		for (int k = 0; k < r; k++)
			acc += q_round(64'(own_tbl[own*NR+k]) * 64'(other_tbl[oth*NR+k]));
		acc = acc - 64'(t.data_value) + 64'(row_off[t.row_index]) + 64'(col_off[t.col_index]);
		resid = clamp32(acc, rs);
		for (int k = 0; k < r; k++) begin
			oi = own*NR + k;
			ti = oth*NR + k;
			s = rs;
			inner = q_round(resid * 64'(other_tbl[ti]))
				+ q_round(64'(own_tbl[oi]) * 64'(cov_tbl[ti]));
			inner = clamp32(inner, s);
			inc = q_round($signed({33'd0, tau}) * inner);
			grad_tbl[oi] = 32'(clamp32(64'(grad_tbl[oi]) + inc, s));
			if (s)
				sat_tbl[oi] = 1'b1;
		end
	endtask

	task automatic apply_transaction(input in_t t);
		int i;
		out_t o;
		i = t.row_index*NR + t.lane;
		case (t.req_type)
			REQ_LOAD: begin
				if (t.table_select == TBL_ROW_OFF)
					row_off[t.row_index] = t.data_value;
				else if (t.table_select == TBL_COL_OFF)
					col_off[t.row_index] = t.data_value;
				else if (t.table_select == TBL_OWN)
					own_tbl[i] = t.data_value;
				else if (t.table_select == TBL_OTHER)
					other_tbl[i] = t.data_value;
				else if (t.table_select == TBL_COV)
					cov_tbl[i] = t.data_value;
				else if (t.table_select == TBL_GRAD) begin
					grad_tbl[i] = t.data_value;
					sat_tbl[i] = 1'b0;
				end
			end
			REQ_OBS: begin
				accumulate_gradient(t);
				obs_seen++;
			end
			REQ_READ: begin
				o.read_data = grad_tbl[i];
				o.saturated = sat_tbl[i];
				gradient_reads.push_back(o);
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		reads_seen = 0;
		obs_seen = 0;
		for (int i = 0; i < NE*NR; i++) begin
			own_tbl[i] = 0; other_tbl[i] = 0; cov_tbl[i] = 0;
			grad_tbl[i] = 0; sat_tbl[i] = 0;
		end
		for (int i = 0; i < NE; i++) begin
			row_off[i] = 0; col_off[i] = 0;
		end
	end

	assign pending_reads = gradient_reads.size();

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			tau <= STEP_SCALE_RESET;
			mode <= 1'b0;
			rank_cfg <= RANK_RESET;
		end else begin
			if (cfg_write) begin
				if (cfg_index == REG_STEP_SCALE)
					tau <= cfg_data;
				else if (cfg_index == REG_ENTITY_MODE)
					mode <= cfg_data[0];
				else if (cfg_index == REG_RANK_IN_USE)
					rank_cfg <= cfg_data[4:0];
			end
			if (in_valid && !in_stall)
				apply_transaction(in_item);
			if (out_valid && !out_stall) begin
				reads_seen++;
				if (gradient_reads.size() == 0)
					report_mismatch("unexpected result", out_item.read_data, 0);
				else begin
					want = gradient_reads.pop_front();
					if (out_item.read_data !== want.read_data)
						report_mismatch("read_data", out_item.read_data, want.read_data);
					if (out_item.saturated !== want.saturated)
						report_mismatch("saturated", 32'(out_item.saturated),
							32'(want.saturated));
				end
			end
		end
	end
endmodule

// File: sim/sparse_factor_gradient_accumulate_test.sv
// Testbench top: drives load, observation and read transactions and gives the verdict.
module sparse_factor_gradient_accumulate_test;
	import sfga_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NR = MAX_RANK_DEF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_item;
	logic cfg_write = 1'b0;
	logic [1:0] cfg_index = REG_STEP_SCALE;
	logic [30:0] cfg_data = '0;
	int fail_count, pending_reads, reads_seen, obs_seen;
	bit busy_stretch = 1'b0;
	int sent = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	sparse_factor_gradient_accumulate u_dut (
		.clk, .arst_n, .in_valid, .in_stall, .in_item,
		.out_valid, .out_stall, .out_item, .cfg_write, .cfg_index, .cfg_data
	);

	sparse_factor_gradient_accumulate_checker u_check (
		.clk, .arst_n, .in_valid, .in_stall, .in_item, .out_valid, .out_stall,
		.out_item, .cfg_write, .cfg_index, .cfg_data, .fail_count, .pending_reads,
		.reads_seen, .obs_seen
	);

	always @(negedge clk)
		out_stall <= !busy_stretch && ($urandom_range(99) < 23);

	task automatic send(input logic [1:0] rt, input logic [2:0] sel, input logic [9:0] row,
			input logic [9:0] col, input logic [3:0] lane, input logic [31:0] val);
		while (!busy_stretch && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_item <= '{rt, sel, row, col, lane, val};
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		sent++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
		in_valid <= 1'b0;
		wait (pending_reads == 0);
		repeat (300) @(negedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_write <= 1'b1;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	function automatic logic [31:0] rand_val();
		case ($urandom_range(5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom;
			default: return 32'($signed($urandom_range(262143)) - 131072);
		endcase
	endfunction

	// load every lane of an entity in all factor tables, offsets and gradient
	task automatic load_entity(input logic [9:0] e, input bit wide);
		for (int k = 0; k < NR; k++) begin
			for (int s = 0; s < 4; s++)
				send(REQ_LOAD, 3'(s), e, 10'($urandom), 4'(k),
					wide ? rand_val() : 32'($signed($urandom_range(131071)) - 65536));
		end
		send(REQ_LOAD, TBL_ROW_OFF, e, 10'($urandom), 4'($urandom), rand_val());
		send(REQ_LOAD, TBL_COL_OFF, e, 10'($urandom), 4'($urandom), rand_val());
	endtask

	task automatic random_phase(input int n, input int span);
		logic [9:0] a, b;
		for (int i = 0; i < n; i++) begin
			a = 10'($urandom_range(span - 1));
			b = 10'($urandom_range(span - 1));
			case ($urandom_range(9))
				0, 1, 2, 3: send(REQ_OBS, 3'($urandom), a, b, 4'($urandom), rand_val());
				4, 5, 6: send(REQ_READ, 3'($urandom), a, b, 4'($urandom), $urandom);
				7: send(REQ_LOAD, 3'($urandom_range(5)), a, b, 4'($urandom), rand_val());
				8: send(2'd3, 3'($urandom), a, b, 4'($urandom), $urandom);
				default: send(REQ_LOAD, 3'($urandom_range(6, 7)), a, b, 4'($urandom),
					$urandom);
			endcase
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int e = 0; e < 8; e++)
			load_entity(10'(e), e < 4);
		load_entity(10'd1023, 1'b1);
		send(REQ_OBS, TBL_OWN, 10'd0, 10'd1, 4'd0, 32'h7fffffff);
		send(REQ_OBS, TBL_OWN, 10'd1023, 10'd1023, 4'd15, 32'h80000000);
		send(REQ_OBS, TBL_OWN, 10'd2, 10'd3, 4'd0, 32'd0);
		send(REQ_READ, TBL_OWN, 10'd0, 10'd0, 4'd0, 32'd0);
		send(REQ_READ, TBL_COL_OFF, 10'd1023, 10'd0, 4'd15, 32'hffffffff);
		send(REQ_READ, TBL_OWN, 10'd2, 10'd0, 4'd7, 32'd0);
		send(REQ_LOAD, TBL_GRAD, 10'd0, 10'd0, 4'd0, 32'd5);
		send(REQ_READ, TBL_OWN, 10'd0, 10'd0, 4'd0, 32'd0);
		send(2'd3, 3'd7, 10'd0, 10'd0, 4'd0, 32'd0);
		send(REQ_LOAD, 3'd6, 10'd0, 10'd0, 4'd0, 32'd9);
		random_phase(150, 8);
		busy_stretch = 1'b1;
		write_reg(REG_STEP_SCALE, 31'h7fffffff);
		write_reg(REG_RANK_IN_USE, 31'd1);
		random_phase(170, 8);
		busy_stretch = 1'b0;
		write_reg(REG_ENTITY_MODE, 31'd1);
		write_reg(REG_STEP_SCALE, 31'd0);
		write_reg(REG_RANK_IN_USE, 31'd31);
		random_phase(170, 8);
		write_reg(REG_RANK_IN_USE, 31'd0);
		random_phase(80, 8);
		write_reg(REG_STEP_SCALE, 31'd1024);
		write_reg(REG_RANK_IN_USE, 31'd7);
		write_reg(REG_ENTITY_MODE, 31'd0);
		random_phase(200, 8);
		write_reg(REG_STEP_SCALE, 31'd65536);
		write_reg(REG_RANK_IN_USE, 31'd16);
		random_phase(176, 8);
		in_valid <= 1'b0;
		wait (pending_reads == 0);
		repeat (100) @(posedge clk);
		$display("sent %0d transactions, %0d observations, %0d reads checked",
			sent, obs_seen, reads_seen);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
